FILE: rtl/core/atsl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package atsl_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int GAIN_W        = 25;
  localparam int CORDIC_STAGES = 28;
  localparam int IDX_W         = $clog2(CORDIC_STAGES);

  // product of magnitude and gain, then headroom for cordic growth and sign
  localparam int Y0_W = SAMPLE_BITS + GAIN_W;
  localparam int XW   = Y0_W + 3;
  // angle: 2^30 per quarter turn, signed
  localparam int ZW   = 32;
  localparam int ZCW  = ZW - 1;
  localparam int ANGLE_SHIFT = 30;
  localparam int PROD_W = ZCW + SAMPLE_BITS - 1;

  // total register stages: input, multiply, cordic, clamp, scale, output
  localparam int NUM_STAGES  = CORDIC_STAGES + 5;
  localparam int CORDIC_BASE = 2;
  localparam int CLAMP_ST    = CORDIC_BASE + CORDIC_STAGES;
  localparam int SCALE_ST    = CLAMP_ST + 1;
  localparam int OUT_ST      = SCALE_ST + 1;

  localparam logic [SAMPLE_BITS-2:0] FULL_SCALE   = '1;
  localparam logic [ZCW-1:0]         QUARTER_TURN = ZCW'(1) << ANGLE_SHIFT;
  localparam logic [GAIN_W-1:0]      GAIN_RESET   = GAIN_W'(65536);

  localparam logic signed [XW-1:0] X_INIT =
    {{(XW - SAMPLE_BITS - 15){1'b0}}, FULL_SCALE, 16'b0};

  localparam int ADDR_W = 3;
  localparam logic REG_GAIN = 1'b0;

  typedef logic [SAMPLE_BITS-1:0] mag_t;

  // round(atan(2^-i) * 2^31 / pi)
  function automatic logic signed [ZW-1:0] atan_entry(input logic [IDX_W-1:0] idx);
    logic signed [ZW-1:0] r;
    unique case (idx)
      5'd0:  r = 32'sd536870912;
      5'd1:  r = 32'sd316933406;
      5'd2:  r = 32'sd167458907;
      5'd3:  r = 32'sd85004756;
      5'd4:  r = 32'sd42667331;
      5'd5:  r = 32'sd21354465;
      5'd6:  r = 32'sd10679838;
      5'd7:  r = 32'sd5340245;
      5'd8:  r = 32'sd2670163;
      5'd9:  r = 32'sd1335087;
      5'd10: r = 32'sd667544;
      5'd11: r = 32'sd333772;
      5'd12: r = 32'sd166886;
      5'd13: r = 32'sd83443;
      5'd14: r = 32'sd41722;
      5'd15: r = 32'sd20861;
      5'd16: r = 32'sd10430;
      5'd17: r = 32'sd5215;
      5'd18: r = 32'sd2608;
      5'd19: r = 32'sd1304;
      5'd20: r = 32'sd652;
      5'd21: r = 32'sd326;
      5'd22: r = 32'sd163;
      5'd23: r = 32'sd81;
      5'd24: r = 32'sd41;
      5'd25: r = 32'sd20;
      5'd26: r = 32'sd10;
      5'd27: r = 32'sd5;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/arctangent_soft_limiter.sv
`timescale 1ns / 1ps
`default_nettype none
// Arctangent soft limiter for signed audio samples.
// Input channel: sample_in with in_valid/in_ready; output channel: sample_out
// with out_valid/out_ready. A beat moves when valid and ready are both high.
// Each input beat gives exactly one output beat, in order:
//   sample_out = trunc(atan(sample_in * gain / 32767) * (2/pi) * 32767).
// The gain register (Q16, 65536 = 1.0) sits at APB address 0; the user must
// write it only while the pipeline is empty, and the block does not enforce this.
// Throughput: one sample per cycle while out_ready stays high. There are 33
// register stages: input, gain multiply, 28 cordic iterations, angle clamp,
// full-scale multiply, output register.
// Each stage has its own valid bit and moves when the next stage is empty
// or moving, so bubbles close up and a stalled receiver first fills the
// pipeline before in_ready drops; nothing is lost or repeated.
// Reset (rst, synchronous) clears all valid bits and loads gain = 1.0.
module arctangent_soft_limiter
  import atsl_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0]      sample_out,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ADDR_W-1:0]             paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  logic [GAIN_W-1:0] gain;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_GAIN) ? 32'(gain) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_GAIN) begin
      gain <= pwdata[GAIN_W-1:0];
    end
  end

  // stage valids and enables
  logic [NUM_STAGES-1:0] v;
  logic [NUM_STAGES-1:0] en;

  always_comb begin
    en[NUM_STAGES-1] = !v[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // sign and zero flags ride along with the data
  logic [NUM_STAGES-2:0] neg_q;
  logic [NUM_STAGES-2:0] zero_q;

  // stage 0: magnitude; the most negative sample wraps to 2^(n-1) unsigned
  mag_t mag_q;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      neg_q[0]  <= sample_in[SAMPLE_BITS-1];
      zero_q[0] <= (sample_in == '0) || (gain == '0);
      mag_q     <= sample_in[SAMPLE_BITS-1] ? mag_t'(-sample_in) : mag_t'(sample_in);
    end
    for (int k = 1; k < NUM_STAGES - 1; k++) begin
      if (en[k]) begin
        neg_q[k]  <= neg_q[k-1];
        zero_q[k] <= zero_q[k-1];
      end
    end
  end

  // stage 1: y0 = |s| * gain, x0 = full scale in Q16
  logic signed [XW-1:0] x_s [CORDIC_STAGES+1];
  logic signed [XW-1:0] y_s [CORDIC_STAGES+1];
  logic signed [ZW-1:0] z_s [CORDIC_STAGES+1];
  logic [Y0_W-1:0]      y0_prod;

  assign y0_prod = Y0_W'(mag_q) * Y0_W'(gain);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      x_s[0] <= X_INIT;
      y_s[0] <= XW'(y0_prod);
      z_s[0] <= '0;
    end
  end

  // cordic vectoring iterations, one per stage
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] ang;

    assign dx  = y_s[i] >>> i;
    assign dy  = x_s[i] >>> i;
    assign ang = atan_entry(IDX_W'(i));

    always_ff @(posedge clk) begin
      if (en[CORDIC_BASE + i]) begin
        if (!y_s[i][XW-1]) begin
          x_s[i+1] <= x_s[i] + dx;
          y_s[i+1] <= y_s[i] - dy;
          z_s[i+1] <= z_s[i] + ang;
        end else begin
          x_s[i+1] <= x_s[i] - dx;
          y_s[i+1] <= y_s[i] + dy;
          z_s[i+1] <= z_s[i] - ang;
        end
      end
    end
  end

  // clamp angle to [0, quarter turn]
  logic [ZCW-1:0] z_clamped;
  logic signed [ZW-1:0] z_fin;

  assign z_fin = z_s[CORDIC_STAGES];

  always_ff @(posedge clk) begin
    if (en[CLAMP_ST]) begin
      priority if (z_fin[ZW-1]) begin
        z_clamped <= '0;
      end else if (z_fin[ZCW-1:0] > QUARTER_TURN) begin
        z_clamped <= QUARTER_TURN;
      end else begin
        z_clamped <= z_fin[ZCW-1:0];
      end
    end
  end

  // scale to full scale and truncate
  logic [PROD_W-1:0]      scale_prod;
  logic [SAMPLE_BITS-1:0] scaled;
  logic [SAMPLE_BITS-1:0] mag_out;

  assign scale_prod = PROD_W'(z_clamped) * PROD_W'(FULL_SCALE);
  assign scaled     = scale_prod[ANGLE_SHIFT +: SAMPLE_BITS];

  always_ff @(posedge clk) begin
    if (en[SCALE_ST]) begin
      mag_out <= (scaled > SAMPLE_BITS'(FULL_SCALE)) ? SAMPLE_BITS'(FULL_SCALE) : scaled;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en[OUT_ST]) begin
      priority if (zero_q[OUT_ST-1]) begin
        sample_out <= '0;
      end else if (neg_q[OUT_ST-1]) begin
        sample_out <= -$signed(mag_out);
      end else begin
        sample_out <= $signed(mag_out);
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/atsl_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module atsl_checker
  import atsl_pkg::*;
(
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic signed [SAMPLE_BITS-1:0] sample_out,
  input wire logic                          pready
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out))
    else $error("output beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // result is limited to plus or minus full scale
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sample_out != {1'b1, {(SAMPLE_BITS-1){1'b0}}})
    else $error("output outside full scale");

  // an empty output stage means the whole pipeline can move
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("config port not ready");

endmodule

bind arctangent_soft_limiter atsl_checker u_atsl_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .sample_out (sample_out),
  .pready     (pready)
);
`default_nettype wire

FILE: dv/arctangent_soft_limiter_tb.sv
`timescale 1ns / 1ps
module arctangent_soft_limiter_tb;
  import atsl_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam longint FS_L = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint QUARTER_L = longint'(1) << ANGLE_SHIFT;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic in_valid = 1'b0;
  logic in_ready;
  sample_t sample_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sample_t sample_out;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // atan(2^-i) in 2^30 units per quarter turn
  longint angle_step [0:CORDIC_STAGES-1] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5
  };

  logic [GAIN_W-1:0] gain_q = GAIN_RESET;
  sample_t pending_samples[$];
  sample_t limited_expect[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_go = 1'b0;
  int hold_left = 0;
  int mismatch_count = 0;

  arctangent_soft_limiter i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk = ~clk;

  // soft-limited sample for a given input and gain
  function automatic sample_t limit_sample(input sample_t s, input logic [GAIN_W-1:0] g);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint mag;
    longint m;
    logic neg;
    neg = s[SAMPLE_BITS-1];
    mag = neg ? -longint'(s) : longint'(s);
    if (mag == 0 || g == '0) begin
      return '0;
    end
    x = FS_L * 65536;
    y = mag * longint'(g);
    z = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + angle_step[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - angle_step[i];
      end
    end
    if (z < 0) z = 0;
    if (z > QUARTER_L) z = QUARTER_L;
    m = (z * FS_L) >>> ANGLE_SHIFT;
    if (m > FS_L) m = FS_L;
    return SAMPLE_BITS'(neg ? -m : m);
  endfunction

  // input driver, also records the expected result of each accepted beat
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) limited_expect.push_back(limit_sample(sample_in, gain_q));
      if (!in_valid || in_ready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          sample_in <= pending_samples.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= 300;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // output monitor
  always @(posedge clk) begin : check_beat
    sample_t want;
    if (!rst && out_valid && out_ready) begin
      if (limited_expect.size() == 0) begin
        if (mismatch_count < 10) $display("unexpected output beat: got %0d", sample_out);
        mismatch_count++;
      end else begin
        want = limited_expect.pop_front();
        if (sample_out !== want) begin
          if (mismatch_count < 10)
            $display("sample_out wrong: expected %0d, got %0d", want, sample_out);
          mismatch_count++;
        end
      end
    end
  end

  task automatic write_gain(input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * int'(REG_GAIN));
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    gain_q <= value[GAIN_W-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending_samples.size() != 0 || in_valid || limited_expect.size() != 0)
      @(posedge clk);
  endtask

  function automatic sample_t random_sample();
    case ($urandom_range(9))
      6, 7: return sample_t'(int'($urandom_range(512)) - 256);
      8: begin
        case ($urandom_range(4))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sh0000;
          3: return 16'sh0001;
          default: return 16'shffff;
        endcase
      end
      9: return sample_t'($urandom_range(1) ? 32767 - $urandom_range(64)
                                            : -32768 + $urandom_range(64));
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] random_gain();
    case ($urandom_range(9))
      0: return 32'd20861;    // strength -1
      1: return 32'd65536;
      2: return 32'd205887;
      3: return 32'd646819;
      4: return 32'd2032049;
      5: return 32'd6383758;
      6: return 32'd20055308; // strength 5
      7: return 32'h01ff_ffff;
      8: return 32'(1 + $urandom_range(255));
      default: return 32'($urandom_range(33554431));
    endcase
  endfunction

  task automatic load_samples(input sample_t vals[$]);
    foreach (vals[i]) pending_samples.push_back(vals[i]);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset gain, extremes and sign patterns
    load_samples('{16'sh0000, 16'sh0001, 16'shffff, 16'sh7fff, 16'sh8000, 16'sh0002,
                   16'shfffe, 16'sh4000, 16'shc000, 16'sh5555, 16'shaaaa, 16'sh0064});
    wait_drained();

    // zero gain forces zero output
    write_gain(32'd0);
    load_samples('{16'sh7fff, 16'sh8000, 16'sh0001});
    wait_drained();

    // largest gain saturates toward full scale
    write_gain(32'h01ff_ffff);
    load_samples('{16'sh0001, 16'shffff, 16'sh7fff, 16'sh8000, 16'sh012c});
    wait_drained();

    // smallest nonzero gain
    write_gain(32'd1);
    load_samples('{16'sh7fff, 16'sh8000, 16'sh0001});
    wait_drained();

    // bits above the register width are dropped
    write_gain(32'hfe03_0000);
    load_samples('{16'sh1234, 16'shedcc});
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      write_gain(random_gain());
      case (ph % 4)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 50; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 50; end
        default: begin send_idle_pct <= 12; recv_stall_pct <= 12; end
      endcase
      @(posedge clk);
      repeat (190) pending_samples.push_back(random_sample());
      wait_drained();
    end

    // receiver holds off while the sender keeps pushing
    write_gain(32'd205887);
    send_idle_pct <= 0;
    recv_stall_pct <= 0;
    @(posedge clk);
    repeat (120) pending_samples.push_back(random_sample());
    repeat (4) @(posedge clk);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    wait_drained();

    repeat (NUM_STAGES + 10) @(posedge clk);
    if (mismatch_count == 0 && limited_expect.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
